// File: src/tes_pkg.sv
package tes_pkg;

	// Ring table geometry.
	localparam int TABLE_DEPTH = 16;
	localparam int IDX_W       = $clog2(TABLE_DEPTH);

	// Field widths.
	localparam int TIME_W  = 32;
	localparam int DELAY_W = 31;
	localparam int CODE_W  = 8;
	localparam int TDATA_W = 16;
	localparam int CFG_IDX_W = 2;

	// Code that means "no target".
	localparam logic [CODE_W-1:0] NO_TARGET = 8'hFF;

	// Register reset values.
	localparam logic [DELAY_W-1:0] DELAY_A_RST = 31'd1200;
	localparam logic [DELAY_W-1:0] DELAY_B_RST = 31'd200;
	localparam logic [CODE_W-1:0]  CODE_A_RST  = 8'h31;
	localparam logic [CODE_W-1:0]  CODE_B_RST  = 8'h32;

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] REG_DELAY_A = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_DELAY_B = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_CODE_A  = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_CODE_B  = 2'd3;

	// Ejector routing of one table entry.
	typedef enum logic [1:0] {
		SEL_NONE = 2'd0,
		SEL_A    = 2'd1,
		SEL_B    = 2'd2
	} sel_t;

endpackage

// File: src/timed_eject_scheduler_core.sv
// Timed eject scheduler for a sorting conveyor. Each item on the s_ stream
// is one tick: the block advances its 32-bit time counter, then, when
// system_enable is set, walks the 16-entry ring table one entry per cycle
// through a single shared subtractor, firing every pending entry whose due
// time has been reached (signed 32-bit difference, safe across wrap). A final
// insert cycle stores a detection, if any, at the write pointer, due at
// time plus delay_a or delay_b, and loads the result item into the output
// register. An enabled tick goes through the scan of all 16 entries and then
// the insert cycle; a disabled tick skips the walk and goes straight to the
// insert cycle. The insert cycle stretches for as long as an earlier result
// item still waits for m_tready. The block holds one tick at a time; s_tready
// returns high once the result is in the output register, even while that
// result still waits for m_tready. The table is empty after reset with no
// clearing pass. Configuration writes are always accepted on the cfg port.
module timed_eject_scheduler_core (
	input  logic                            clk,
	input  logic                            arst_n,
	// Tick input.
	input  logic                            s_tvalid,
	output logic                            s_tready,
	// [0] system_enable, [1] detect_valid, [9:2] target_code, rest zero.
	input  logic [tes_pkg::TDATA_W-1:0]     s_tdata,
	// Tick result.
	output logic                            m_tvalid,
	input  logic                            m_tready,
	// [0] fire_a, [1] fire_b, [9:2] last_valid_code, rest zero.
	output logic [tes_pkg::TDATA_W-1:0]     m_tdata,
	// Configuration write channel.
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [tes_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [tes_pkg::DELAY_W-1:0]     cfg_data
);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_INSERT
	} state_t;

	state_t state_q;

	// Configuration registers.
	logic [tes_pkg::DELAY_W-1:0] delay_a_q;
	logic [tes_pkg::DELAY_W-1:0] delay_b_q;
	logic [tes_pkg::CODE_W-1:0]  code_a_q;
	logic [tes_pkg::CODE_W-1:0]  code_b_q;

	// Scheduler state.
	logic [tes_pkg::TIME_W-1:0]  time_q;
	logic [tes_pkg::IDX_W-1:0]   wr_idx_q;
	logic [tes_pkg::IDX_W-1:0]   scan_idx_q;
	logic [tes_pkg::CODE_W-1:0]  recent_q;
	logic [tes_pkg::TIME_W-1:0]  due_q  [tes_pkg::TABLE_DEPTH];
	tes_pkg::sel_t               sel_q  [tes_pkg::TABLE_DEPTH];
	logic                        done_q [tes_pkg::TABLE_DEPTH];

	// The tick in progress.
	logic                        en_q;
	logic                        det_q;
	logic [tes_pkg::CODE_W-1:0]  code_q;
	logic                        fa_q;
	logic                        fb_q;

	// Output register.
	logic                        m_valid_q;
	logic [tes_pkg::TDATA_W-1:0] m_data_q;

	logic                        in_acc;
	logic                        cfg_acc;
	logic [tes_pkg::TIME_W-1:0]  diff;
	logic                        hit;
	logic                        out_free;
	logic                        out_load;
	logic                        match_a;
	logic                        match_b;
	logic [tes_pkg::CODE_W-1:0]  recent_nxt;
	logic [tes_pkg::TIME_W-1:0]  due_new;
	tes_pkg::sel_t               sel_new;
	logic [tes_pkg::IDX_W-1:0]   wr_idx_nxt;

	assign s_tready  = (state_q == ST_IDLE);
	assign in_acc    = s_tvalid && s_tready;
	assign cfg_ready = 1'b1;
	assign cfg_acc   = cfg_valid && cfg_ready;
	assign m_tvalid  = m_valid_q;
	assign m_tdata   = m_data_q;
	assign out_free  = !m_valid_q || m_tready;
	// The insert cycle completes and loads the output register.
	assign out_load  = (state_q == ST_INSERT) && out_free;

	// The shared compare unit: an entry is due when time - due is not negative.
	assign diff = time_q - due_q[scan_idx_q];
	assign hit  = !done_q[scan_idx_q] && (sel_q[scan_idx_q] != tes_pkg::SEL_NONE)
		&& !diff[tes_pkg::TIME_W-1];

	// The no-target code never schedules, even if a code register holds it.
	// Ejector A wins when both code registers are equal.
	assign match_a = (code_q != tes_pkg::NO_TARGET) && (code_q == code_a_q);
	assign match_b = (code_q != tes_pkg::NO_TARGET) && (code_q == code_b_q);

	always_comb begin
		if (match_a) begin
			due_new = time_q + {1'b0, delay_a_q};
			sel_new = tes_pkg::SEL_A;
		end else if (match_b) begin
			due_new = time_q + {1'b0, delay_b_q};
			sel_new = tes_pkg::SEL_B;
		end else begin
			due_new = '0;
			sel_new = tes_pkg::SEL_NONE;
		end
	end

	assign recent_nxt = (det_q && (code_q != tes_pkg::NO_TARGET)) ? code_q : recent_q;
	assign wr_idx_nxt = (wr_idx_q == tes_pkg::IDX_W'(tes_pkg::TABLE_DEPTH - 1))
		? '0 : wr_idx_q + 1'b1;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			delay_a_q <= tes_pkg::DELAY_A_RST;
			delay_b_q <= tes_pkg::DELAY_B_RST;
			code_a_q  <= tes_pkg::CODE_A_RST;
			code_b_q  <= tes_pkg::CODE_B_RST;
		end else if (cfg_acc) begin
			case (cfg_index)
				tes_pkg::REG_DELAY_A: delay_a_q <= cfg_data;
				tes_pkg::REG_DELAY_B: delay_b_q <= cfg_data;
				tes_pkg::REG_CODE_A:  code_a_q  <= cfg_data[tes_pkg::CODE_W-1:0];
				tes_pkg::REG_CODE_B:  code_b_q  <= cfg_data[tes_pkg::CODE_W-1:0];
				default: ;
			endcase
		end
	end

	// Due times need no reset: an entry routed to no ejector never reads its due time.
	always_ff @(posedge clk) begin
		if (state_q == ST_INSERT && out_free && det_q) begin
			due_q[wr_idx_q] <= due_new;
		end
	end

	// Sequencer, table control state and registered outputs.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			time_q     <= '0;
			wr_idx_q   <= '0;
			scan_idx_q <= '0;
			recent_q   <= tes_pkg::NO_TARGET;
			en_q       <= 1'b0;
			det_q      <= 1'b0;
			code_q     <= '0;
			fa_q       <= 1'b0;
			fb_q       <= 1'b0;
			m_valid_q  <= 1'b0;
			m_data_q   <= '0;
			for (int i = 0; i < tes_pkg::TABLE_DEPTH; i++) begin
				sel_q[i]  <= tes_pkg::SEL_NONE;
				done_q[i] <= 1'b0;
			end
		end else begin
			// The output register is loaded by the insert cycle and emptied
			// when the result item is taken.
			if (out_load) begin
				m_valid_q <= 1'b1;
			end else if (m_valid_q && m_tready) begin
				m_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_acc) begin
						time_q     <= time_q + 1'b1;
						en_q       <= s_tdata[0];
						det_q      <= s_tdata[1];
						code_q     <= s_tdata[tes_pkg::CODE_W+1:2];
						fa_q       <= 1'b0;
						fb_q       <= 1'b0;
						scan_idx_q <= '0;
						state_q    <= s_tdata[0] ? ST_SCAN : ST_INSERT;
					end
				end
				ST_SCAN: begin
					if (hit) begin
						done_q[scan_idx_q] <= 1'b1;
						if (sel_q[scan_idx_q] == tes_pkg::SEL_A) begin
							fa_q <= 1'b1;
						end
						if (sel_q[scan_idx_q] == tes_pkg::SEL_B) begin
							fb_q <= 1'b1;
						end
					end
					if (scan_idx_q == tes_pkg::IDX_W'(tes_pkg::TABLE_DEPTH - 1)) begin
						scan_idx_q <= '0;
						state_q    <= ST_INSERT;
					end else begin
						scan_idx_q <= scan_idx_q + 1'b1;
					end
				end
				ST_INSERT: begin
					// Wait here until the output register can take the result.
					if (out_free) begin
						if (det_q) begin
							done_q[wr_idx_q] <= 1'b0;
							sel_q[wr_idx_q]  <= sel_new;
							wr_idx_q         <= wr_idx_nxt;
						end
						recent_q  <= recent_nxt;
						m_data_q  <= {{(tes_pkg::TDATA_W - tes_pkg::CODE_W - 2){1'b0}},
							recent_nxt, fb_q, fa_q};
						state_q   <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// One tick at a time: after acceptance the input side closes.
	assert property (@(posedge clk) disable iff (!arst_n)
		in_acc |=> !s_tready)
		else $error("input accepted while a tick is in progress");

	// Time advances by exactly one per accepted tick.
	assert property (@(posedge clk) disable iff (!arst_n)
		in_acc |=> (time_q == $past(time_q) + 1'b1))
		else $error("time counter did not advance by one");

	// A scan always starts from the first entry.
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE) |-> (scan_idx_q == '0))
		else $error("scan index not parked at zero while idle");

	// A tick with system_enable clear fires nothing.
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_INSERT && !en_q) |-> (!fa_q && !fb_q))
		else $error("fire flag raised on a disabled tick");

endmodule

// File: verif/tb_top.sv
`timescale 1ns / 100ps

// Testbench for timed_eject_scheduler_core. Every item on the tick stream is
// one conveyor tick. A predictor mirrors the ring table, the time counter
// and the four configuration registers, and queues the result item that
// each accepted tick must produce. A separate process compares every
// accepted result item, field by field, with the oldest queued one.
module tb_top;

	localparam int CLK_HALF     = 6;
	localparam int RESET_CYCLES = 10;
	localparam int SETTLE_CYCLES = 24;
	localparam int DRAIN_LIMIT   = 20000;
	// About ten times the slowest expected run.
	localparam int RUN_LIMIT_NS  = 7_200_000;

	typedef struct {
		logic                       enable;
		logic                       detect;
		logic [tes_pkg::CODE_W-1:0] code;
	} tick_in_t;

	typedef struct {
		logic                       fire_a;
		logic                       fire_b;
		logic [tes_pkg::CODE_W-1:0] last_code;
	} tick_out_t;

	logic                          clk;
	logic                          arst_n;
	logic                          s_tvalid;
	logic                          s_tready;
	logic [tes_pkg::TDATA_W-1:0]   s_tdata;
	logic                          m_tvalid;
	logic                          m_tready;
	logic [tes_pkg::TDATA_W-1:0]   m_tdata;
	logic                          cfg_valid;
	logic                          cfg_ready;
	logic [tes_pkg::CFG_IDX_W-1:0] cfg_index;
	logic [tes_pkg::DELAY_W-1:0]   cfg_data;

	// Predictor copy of the configuration registers.
	logic [tes_pkg::DELAY_W-1:0] set_delay_a;
	logic [tes_pkg::DELAY_W-1:0] set_delay_b;
	logic [tes_pkg::CODE_W-1:0]  set_code_a;
	logic [tes_pkg::CODE_W-1:0]  set_code_b;

	// Predictor copy of the scheduler state.
	logic [tes_pkg::TIME_W-1:0] sched_time;
	logic [tes_pkg::IDX_W-1:0]  sched_wr;
	logic [tes_pkg::TIME_W-1:0] sched_due [tes_pkg::TABLE_DEPTH];
	tes_pkg::sel_t              sched_route [tes_pkg::TABLE_DEPTH];
	logic                       sched_done [tes_pkg::TABLE_DEPTH];
	logic [tes_pkg::CODE_W-1:0] sched_last_code;

	// Result items still owed by the block, oldest first.
	tick_out_t pending_results[$];

	int tx_idle_pct;
	int rx_idle_pct;
	int disabled_left;
	int errors;
	int ticks_sent;
	int results_checked;
	int fires_a_seen;
	int fires_b_seen;
	int double_fires;
	int cfg_writes;

	timed_eject_scheduler_core i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #CLK_HALF clk = ~clk;
	end

	// A hard stop in case the block hangs somewhere.
	initial begin
		#RUN_LIMIT_NS;
		$display("Timeout at %0t with %0d result items outstanding",
			$time, pending_results.size());
		$display("TB_ERROR");
		$finish;
	end

	// Clears the predictor to the state that reset leaves in the block.
	function automatic void schedule_reset();
		int i;
		set_delay_a     = tes_pkg::DELAY_A_RST;
		set_delay_b     = tes_pkg::DELAY_B_RST;
		set_code_a      = tes_pkg::CODE_A_RST;
		set_code_b      = tes_pkg::CODE_B_RST;
		sched_time      = '0;
		sched_wr        = '0;
		sched_last_code = tes_pkg::NO_TARGET;
		for (i = 0; i < tes_pkg::TABLE_DEPTH; i++) begin
			sched_due[i]   = '0;
			sched_route[i] = tes_pkg::SEL_NONE;
			sched_done[i]  = 1'b0;
		end
	endfunction

	// Advances the predicted scheduler by one tick and returns the result
	// item the block must produce for it. The table walk runs before the
	// insert, so a detection never fires on its own tick.
	function automatic tick_out_t advance_schedule(tick_in_t t);
		tick_out_t                  r;
		logic [tes_pkg::TIME_W-1:0] age;
		int                         i;
		r.fire_a   = 1'b0;
		r.fire_b   = 1'b0;
		sched_time = sched_time + 1;
		if (t.enable) begin
			for (i = 0; i < tes_pkg::TABLE_DEPTH; i++) begin
				// Due once the signed difference is non-negative, safe across wrap.
				age = sched_time - sched_due[i];
				if (!sched_done[i] && sched_route[i] != tes_pkg::SEL_NONE
					&& !age[tes_pkg::TIME_W-1]) begin
					if (sched_route[i] == tes_pkg::SEL_A)
						r.fire_a = 1'b1;
					else if (sched_route[i] == tes_pkg::SEL_B)
						r.fire_b = 1'b1;
					sched_done[i] = 1'b1;
				end
			end
		end
		if (t.detect) begin
			// The write pointer overwrites the oldest slot when the ring is full.
			sched_done[sched_wr] = 1'b0;
			if (t.code != tes_pkg::NO_TARGET)
				sched_last_code = t.code;
			// Ejector A wins when both code registers hold the same code, and the
			// no-target code never schedules, whatever the registers hold.
			if (t.code != tes_pkg::NO_TARGET && t.code == set_code_a) begin
				sched_due[sched_wr]   = sched_time + tes_pkg::TIME_W'(set_delay_a);
				sched_route[sched_wr] = tes_pkg::SEL_A;
			end else if (t.code != tes_pkg::NO_TARGET && t.code == set_code_b) begin
				sched_due[sched_wr]   = sched_time + tes_pkg::TIME_W'(set_delay_b);
				sched_route[sched_wr] = tes_pkg::SEL_B;
			end else begin
				sched_due[sched_wr]   = '0;
				sched_route[sched_wr] = tes_pkg::SEL_NONE;
			end
			sched_wr = sched_wr + 1'b1;
		end
		r.last_code = sched_last_code;
		return r;
	endfunction

	// Draws one random tick. Most detections carry one of the two routed
	// codes so that entries fire often; now and then a run of disabled ticks
	// lets due entries pile up so that both ejectors fire together.
	function automatic tick_in_t random_tick();
		tick_in_t t;
		int       pick;
		if (disabled_left > 0) begin
			disabled_left--;
			t.enable = 1'b0;
		end else if ($urandom_range(49) == 0) begin
			disabled_left = $urandom_range(20, 4);
			t.enable      = 1'b0;
		end else begin
			t.enable = ($urandom_range(99) < 92);
		end
		t.detect = ($urandom_range(99) < 65);
		pick     = $urandom_range(9);
		if (pick < 3)
			t.code = set_code_a;
		else if (pick < 6)
			t.code = set_code_b;
		else if (pick == 6)
			t.code = tes_pkg::NO_TARGET;
		else
			t.code = tes_pkg::CODE_W'($urandom_range(255));
		return t;
	endfunction

	// The receiver stalls at random, at the rate of the current phase.
	always @(negedge clk) begin
		m_tready <= ($urandom_range(99) >= rx_idle_pct);
	end

	// Compares each accepted result item with the oldest prediction.
	always @(posedge clk) begin
		tick_out_t    want;
		logic         got_a;
		logic         got_b;
		logic [tes_pkg::CODE_W-1:0] got_code;
		if (arst_n && m_tvalid && m_tready) begin
			got_a    = m_tdata[0];
			got_b    = m_tdata[1];
			got_code = m_tdata[tes_pkg::CODE_W+1:2];
			if (pending_results.size() == 0) begin
				errors++;
				$display("%0t: unexpected result item, expected none, actual m_tdata %h",
					$time, m_tdata);
			end else begin
				want = pending_results.pop_front();
				results_checked++;
				if (got_a !== want.fire_a) begin
					errors++;
					$display("%0t: fire_a mismatch, expected %0b actual %0b",
						$time, want.fire_a, got_a);
				end
				if (got_b !== want.fire_b) begin
					errors++;
					$display("%0t: fire_b mismatch, expected %0b actual %0b",
						$time, want.fire_b, got_b);
				end
				if (got_code !== want.last_code) begin
					errors++;
					$display("%0t: last_valid_code mismatch, expected %h actual %h",
						$time, want.last_code, got_code);
				end
				if (want.fire_a)
					fires_a_seen++;
				if (want.fire_b)
					fires_b_seen++;
				if (want.fire_a && want.fire_b)
					double_fires++;
			end
		end
	end

	// Sends one tick item, after a random gap, and queues its prediction
	// once the block has taken it.
	task automatic send_tick(input tick_in_t t);
		while ($urandom_range(99) < tx_idle_pct) begin
			@(negedge clk);
			s_tvalid <= 1'b0;
		end
		@(negedge clk);
		s_tvalid <= 1'b1;
		s_tdata  <= {{(tes_pkg::TDATA_W-tes_pkg::CODE_W-2){1'b0}},
			t.code, t.detect, t.enable};
		do @(posedge clk); while (!s_tready);
		pending_results.push_back(advance_schedule(t));
		ticks_sent++;
	endtask

	task automatic send_fields(input logic en, input logic det,
		input logic [tes_pkg::CODE_W-1:0] code);
		tick_in_t t;
		t.enable = en;
		t.detect = det;
		t.code   = code;
		send_tick(t);
	endtask

	// Holds the sender off until every queued result item has arrived and the
	// block has had time to finish its table walk.
	task automatic drain_results();
		int waited;
		waited = 0;
		@(negedge clk);
		s_tvalid <= 1'b0;
		while (pending_results.size() != 0 && waited < DRAIN_LIMIT) begin
			@(posedge clk);
			waited++;
		end
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Writes one configuration register; only ever called with the block idle.
	task automatic write_reg(input logic [tes_pkg::CFG_IDX_W-1:0] idx,
		input logic [tes_pkg::DELAY_W-1:0] value);
		drain_results();
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			tes_pkg::REG_DELAY_A: begin
				set_delay_a = value;
			end
			tes_pkg::REG_DELAY_B: begin
				set_delay_b = value;
			end
			tes_pkg::REG_CODE_A: begin
				set_code_a = value[tes_pkg::CODE_W-1:0];
			end
			tes_pkg::REG_CODE_B: begin
				set_code_b = value[tes_pkg::CODE_W-1:0];
			end
			default: begin
			end
		endcase
		cfg_writes++;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic apply_config(input logic [tes_pkg::DELAY_W-1:0] da,
		input logic [tes_pkg::DELAY_W-1:0] db,
		input logic [tes_pkg::CODE_W-1:0] ca, input logic [tes_pkg::CODE_W-1:0] cb);
		write_reg(tes_pkg::REG_DELAY_A, da);
		write_reg(tes_pkg::REG_DELAY_B, db);
		write_reg(tes_pkg::REG_CODE_A, tes_pkg::DELAY_W'(ca));
		write_reg(tes_pkg::REG_CODE_B, tes_pkg::DELAY_W'(cb));
	endtask

	task automatic set_idling(input int tx_pct, input int rx_pct);
		tx_idle_pct = tx_pct;
		rx_idle_pct = rx_pct;
	endtask

	// Random ticks; every so often the sender waits for all results.
	task automatic test_random_traffic(input int count);
		repeat (count) begin
			send_tick(random_tick());
			if ($urandom_range(59) == 0)
				drain_results();
		end
	endtask

	// Reset values of the registers: both default codes, a no-target code and
	// an unrouted code, then enough random ticks for ejector B to fire.
	task automatic test_reset_config();
		send_fields(1'b1, 1'b1, tes_pkg::CODE_A_RST);
		send_fields(1'b1, 1'b1, tes_pkg::CODE_B_RST);
		send_fields(1'b1, 1'b1, tes_pkg::NO_TARGET);
		send_fields(1'b0, 1'b1, 8'h00);
		send_fields(1'b1, 1'b0, 8'hFF);
		test_random_traffic(300);
	endtask

	// Hand-picked cases, most with short delays so that entries fire soon.
	task automatic test_corner_cases();
		apply_config(31'd0, 31'd2, 8'h10, 8'h20);
		// Zero delay: fires on the next enabled tick, not on its own.
		send_fields(1'b1, 1'b1, 8'h10);
		send_fields(1'b1, 1'b0, 8'h00);
		// A B entry and an A entry, the latter stored on a disabled tick, stay
		// pending, then both ejectors fire on the same enabled tick.
		send_fields(1'b1, 1'b1, 8'h20);
		send_fields(1'b0, 1'b1, 8'h10);
		send_fields(1'b0, 1'b0, 8'h00);
		send_fields(1'b1, 1'b0, 8'hFF);
		// No-target code keeps the last code; unrouted codes take a slot but never fire.
		send_fields(1'b1, 1'b1, tes_pkg::NO_TARGET);
		send_fields(1'b1, 1'b1, 8'h77);
		send_fields(1'b1, 1'b1, 8'h00);
		send_fields(1'b1, 1'b1, 8'hFE);
		// Equal code registers route to ejector A.
		write_reg(tes_pkg::REG_CODE_B, tes_pkg::DELAY_W'(8'h10));
		send_fields(1'b1, 1'b1, 8'h10);
		send_fields(1'b1, 1'b0, 8'h00);
		// A code register holding the no-target code never schedules.
		write_reg(tes_pkg::REG_CODE_A, tes_pkg::DELAY_W'(tes_pkg::NO_TARGET));
		write_reg(tes_pkg::REG_CODE_B, tes_pkg::DELAY_W'(tes_pkg::NO_TARGET));
		send_fields(1'b1, 1'b1, tes_pkg::NO_TARGET);
		send_fields(1'b1, 1'b0, 8'h00);
		// Largest delay: the entry stays in the future for the whole run.
		write_reg(tes_pkg::REG_DELAY_A, 31'h7FFF_FFFF);
		write_reg(tes_pkg::REG_CODE_A, tes_pkg::DELAY_W'(8'h10));
		send_fields(1'b1, 1'b1, 8'h10);
		send_fields(1'b1, 1'b0, 8'h00);
	endtask

	// Random traffic across several register settings and idling profiles.
	task automatic test_config_sweep();
		apply_config(31'd5, 31'd9, 8'h31, tes_pkg::CODE_W'($urandom_range(254)));
		test_random_traffic(270);
		set_idling(86, 31);
		apply_config(31'd0, 31'd0, 8'h5A, 8'h5A);
		test_random_traffic(270);
		apply_config(31'h7FFF_FFFF, 31'd17, tes_pkg::CODE_W'($urandom_range(254)), 8'hA5);
		test_random_traffic(270);
		set_idling(0, 0);
		apply_config(tes_pkg::DELAY_W'($urandom_range(40)),
			tes_pkg::DELAY_W'($urandom_range(40)), tes_pkg::NO_TARGET, 8'h00);
		test_random_traffic(270);
		apply_config(31'd20, 31'd2, 8'hFE, 8'h01);
		test_random_traffic(270);
	endtask

	initial begin
		arst_n        = 1'b0;
		s_tvalid      = 1'b0;
		s_tdata       = '0;
		cfg_valid     = 1'b0;
		cfg_index     = '0;
		cfg_data      = '0;
		disabled_left = 0;
		errors        = 0;
		ticks_sent    = 0;
		results_checked = 0;
		fires_a_seen  = 0;
		fires_b_seen  = 0;
		double_fires  = 0;
		cfg_writes    = 0;
		set_idling(31, 86);
		schedule_reset();
		repeat (RESET_CYCLES) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_reset_config();
		test_corner_cases();
		test_config_sweep();

		drain_results();
		if (pending_results.size() != 0) begin
			errors += pending_results.size();
			$display("%0t: %0d result items never arrived", $time, pending_results.size());
		end
		$display("Sent %0d ticks, checked %0d results over %0d register writes.",
			ticks_sent, results_checked, cfg_writes);
		$display("Ejector A fired %0d times, B %0d times, both together %0d times.",
			fires_a_seen, fires_b_seen, double_fires);
		if (errors == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end

endmodule

// File: files.f
src/tes_pkg.sv
src/timed_eject_scheduler_core.sv
verif/tb_top.sv
